FILE: rtl/core/i2p_pkg.sv
// Package for the infix-to-postfix converter: token codes, stack entry and result types.
`default_nettype none
package i2p_pkg;

  localparam int STACK_DEPTH_DEF = 16;

  localparam logic [2:0] OP_OPERAND  = 3'd0;
  localparam logic [2:0] OP_OPERATOR = 3'd1;
  localparam logic [2:0] OP_LPAREN   = 3'd2;
  localparam logic [2:0] OP_RPAREN   = 3'd3;
  localparam logic [2:0] OP_END      = 3'd4;

  localparam logic [2:0] CAT_ADD    = 3'd0;
  localparam logic [2:0] CAT_MUL    = 3'd1;
  localparam logic [2:0] CAT_REL    = 3'd2;
  localparam logic [2:0] CAT_ASSIGN = 3'd3;
  localparam logic [2:0] CAT_UNARY  = 3'd4;
  localparam logic [2:0] CAT_LOGIC  = 3'd5;

  localparam logic [2:0] KIND_OPERAND  = 3'd0;
  localparam logic [2:0] KIND_OPERATOR = 3'd1;
  localparam logic [2:0] KIND_LPAREN   = 3'd2;
  localparam logic [2:0] KIND_END      = 3'd3;
  localparam logic [2:0] KIND_ERROR    = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_RPAREN   = 2'd2;
  localparam logic [1:0] ST_LPAREN   = 2'd3;

  localparam logic [2:0] PREC_ASSIGN = 3'd0;
  localparam logic [2:0] PREC_REL    = 3'd1;
  localparam logic [2:0] PREC_ADD    = 3'd2;
  localparam logic [2:0] PREC_MUL    = 3'd3;
  localparam logic [2:0] PREC_TOP    = 3'd4;

  typedef struct packed {
    logic        paren;
    logic [2:0]  cat;
    logic [15:0] tref;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [15:0] tref;
    logic [2:0]  kind;
    logic [2:0]  cat;
    logic [1:0]  vtype;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    logic    valid;
    logic    last;
    result_t res;
  } emit_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_FINAL,
    S_DONE
  } seq_state_t;

  function automatic logic [2:0] prec_level(input logic [2:0] cat);
    logic [2:0] lvl;
    unique case (cat)
      CAT_ADD:    lvl = PREC_ADD;
      CAT_MUL:    lvl = PREC_MUL;
      CAT_REL:    lvl = PREC_REL;
      CAT_ASSIGN: lvl = PREC_ASSIGN;
      default:    lvl = PREC_TOP;
    endcase
    return lvl;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/infix_to_postfix_converter_top.sv
// Top level of the infix-to-postfix converter: operator stack RAM, sequencer and output register.
// An accepted operand passes from the token latch through the pending-result register into the
// output register; each stack read (read, then precedence compare) uses the RAM's registered read
// data. Results leave in order, one per popped operator; a matched left paren is popped with no
// result. Unknown tokens give no result. in_ready returns once the last result is in the output register.
// Reset (rst_n low, synchronous) empties the stack and clears out_valid; RAM is not cleared.
`default_nettype none
module infix_to_postfix_converter_top import i2p_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_op,
  input  wire logic [15:0] in_token_ref,
  input  wire logic [2:0]  in_category,
  input  wire logic [1:0]  in_value_type,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_ref,
  output logic [2:0]       out_kind,
  output logic [2:0]       out_category,
  output logic [1:0]       out_type,
  output logic [1:0]       out_status,
  output logic             out_last
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int LW = $clog2(STACK_DEPTH + 1);

  emit_t         emit;
  logic          slot_free;
  logic          stk_we;
  logic [AW-1:0] stk_waddr;
  logic [AW-1:0] stk_raddr;
  entry_t        stk_wdata;
  entry_t        stk_rdata;
  logic [LW-1:0] stk_level;

  logic    out_valid_r;
  result_t out_res_r;
  logic    out_last_r;

  i2p_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  i2p_seq #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_token_ref  (in_token_ref),
    .in_category   (in_category),
    .in_value_type (in_value_type),
    .slot_free     (slot_free),
    .emit          (emit),
    .stk_we        (stk_we),
    .stk_waddr     (stk_waddr),
    .stk_wdata     (stk_wdata),
    .stk_raddr     (stk_raddr),
    .stk_rdata     (stk_rdata),
    .stk_level     (stk_level)
  );

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_res_r  <= emit.res;
      out_last_r <= emit.last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_ref      = out_res_r.tref;
  assign out_kind     = out_res_r.kind;
  assign out_category = out_res_r.cat;
  assign out_type     = out_res_r.vtype;
  assign out_status   = out_res_r.status;
  assign out_last     = out_last_r;

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    emit.valid |-> slot_free)
    else $error("result emitted into an occupied output register");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    stk_we |-> (stk_level < LW'(STACK_DEPTH)))
    else $error("push onto a full stack");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    stk_level <= LW'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit.valid && emit.last) |=> in_ready)
    else $error("not ready after final result of a transaction");

endmodule
`default_nettype wire

FILE: rtl/core/i2p_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module i2p_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/i2p_seq.sv
// Sequencer for the converter: token latch, stack pointer, precedence compare and result hold.
`default_nettype none
module i2p_seq import i2p_pkg::*; #(
  parameter  int STACK_DEPTH = STACK_DEPTH_DEF,
  localparam int AW = $clog2(STACK_DEPTH),
  localparam int LW = $clog2(STACK_DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [2:0]    in_op,
  input  wire logic [15:0]   in_token_ref,
  input  wire logic [2:0]    in_category,
  input  wire logic [1:0]    in_value_type,
  input  wire logic          slot_free,
  output emit_t              emit,
  output logic               stk_we,
  output logic [AW-1:0]      stk_waddr,
  output entry_t             stk_wdata,
  output logic [AW-1:0]      stk_raddr,
  input  wire entry_t        stk_rdata,
  output logic [LW-1:0]      stk_level
);

  seq_state_t  state_r, state_nxt;
  logic [LW-1:0] level_r, level_nxt;
  logic [2:0]  tok_op_r;
  logic [15:0] tok_ref_r;
  logic [2:0]  tok_cat_r;
  logic [1:0]  tok_type_r;
  logic        pend_v_r, pend_v_nxt;
  result_t     pend_r, pend_nxt;

  logic          accept;
  logic          can_produce;
  logic [LW-1:0] level_m1;
  logic          level_empty;
  logic          level_full;
  logic          stop_op;
  logic          cat_bad;
  logic          last_pop;
  logic          final_push;
  logic          final_prod;
  result_t       final_res;
  result_t       pop_res;
  logic          prod;
  result_t       prod_res;

  assign in_ready    = (state_r == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign can_produce = !pend_v_r || slot_free;
  assign level_m1    = level_r - LW'(1);
  assign level_empty = (level_r == '0);
  assign level_full  = (level_r == LW'(STACK_DEPTH));
  assign last_pop    = (level_m1 == '0);
  assign cat_bad     = (in_category > CAT_LOGIC);
  assign stop_op     = stk_rdata.paren ||
                       (prec_level(stk_rdata.cat) < prec_level(tok_cat_r));
  assign stk_level   = level_r;

  assign stk_waddr = AW'(level_r);
  assign stk_raddr = AW'(level_m1);
  assign stk_wdata = '{paren: (tok_op_r == OP_LPAREN),
                       cat:   (tok_op_r == OP_LPAREN) ? CAT_ADD : tok_cat_r,
                       tref:  tok_ref_r};

  assign final_push = ((tok_op_r == OP_OPERATOR) || (tok_op_r == OP_LPAREN)) && !level_full;
  assign final_prod = !final_push;

  always_comb begin
    final_res = '{tref: tok_ref_r, kind: KIND_ERROR, cat: CAT_ADD, vtype: 2'd0,
                  status: ST_OK};
    unique case (tok_op_r)
      OP_OPERAND: begin
        final_res.kind  = KIND_OPERAND;
        final_res.vtype = tok_type_r;
      end
      OP_RPAREN: final_res.status = ST_RPAREN;
      OP_END:    final_res.kind   = KIND_END;
      default:   final_res.status = ST_OVERFLOW;
    endcase
  end

  always_comb begin
    pop_res = '{tref: stk_rdata.tref, kind: KIND_OPERATOR, cat: stk_rdata.cat,
                vtype: 2'd0, status: ST_OK};
    if (tok_op_r == OP_END && stk_rdata.paren) begin
      pop_res.kind   = KIND_LPAREN;
      pop_res.cat    = CAT_ADD;
      pop_res.status = ST_LPAREN;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_OPERAND:  state_nxt = S_FINAL;
            OP_OPERATOR: state_nxt = cat_bad ? S_IDLE : (level_empty ? S_FINAL : S_READ);
            OP_LPAREN:   state_nxt = S_FINAL;
            OP_RPAREN,
            OP_END:      state_nxt = level_empty ? S_FINAL : S_READ;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_READ: state_nxt = S_EVAL;
      S_EVAL: begin
        unique case (tok_op_r)
          OP_OPERATOR: begin
            if (stop_op) begin
              state_nxt = S_FINAL;
            end else if (can_produce) begin
              state_nxt = last_pop ? S_FINAL : S_READ;
            end
          end
          OP_RPAREN: begin
            if (stk_rdata.paren) begin
              state_nxt = S_DONE;
            end else if (can_produce) begin
              state_nxt = last_pop ? S_FINAL : S_READ;
            end
          end
          OP_END: begin
            if (can_produce) begin
              state_nxt = last_pop ? S_FINAL : S_READ;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_FINAL: begin
        if (!final_prod || can_produce) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!pend_v_r || slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    level_nxt  = level_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    emit       = '0;
    stk_we     = 1'b0;
    prod       = 1'b0;
    prod_res   = pop_res;
    unique case (state_r)
      S_EVAL: begin
        if (tok_op_r == OP_RPAREN && stk_rdata.paren) begin
          level_nxt = level_m1;
        end else if (!(tok_op_r == OP_OPERATOR && stop_op)) begin
          prod = 1'b1;
          if (can_produce) begin
            level_nxt = level_m1;
          end
        end
      end
      S_FINAL: begin
        if (final_push) begin
          stk_we    = 1'b1;
          level_nxt = level_r + LW'(1);
        end else begin
          prod     = 1'b1;
          prod_res = final_res;
        end
      end
      S_DONE: begin
        if (pend_v_r && slot_free) begin
          emit.valid = 1'b1;
          emit.last  = 1'b1;
          emit.res   = pend_r;
          pend_v_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
    if (prod && can_produce) begin
      if (pend_v_r) begin
        emit.valid = 1'b1;
        emit.res   = pend_r;
      end
      pend_nxt   = prod_res;
      pend_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      level_r  <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      level_r  <= level_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    if (accept) begin
      tok_op_r   <= in_op;
      tok_ref_r  <= in_token_ref;
      tok_cat_r  <= in_category;
      tok_type_r <= in_value_type;
    end
  end

endmodule
`default_nettype wire
